@@ rtl/exact_integer_root_search_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the exact integer root search block
// All macros sample on i_clk and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EXACT_INTEGER_ROOT_SEARCH_MACROS_SVH
`define EXACT_INTEGER_ROOT_SEARCH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ERS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ERS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ers_pkg.sv @@
// ----------------------------------------------------------------------------
// ers_pkg
// Shared constants and controller/datapath interface types for the exact
// integer root search block.
// ----------------------------------------------------------------------------
package ers_pkg;

    localparam int VALUE_BITS_DEFAULT = 31;
    localparam int EXP_BITS           = 6;
    localparam int MUL_PARTIALS       = 4;
    localparam int MUL_CNT_BITS       = 3;

    typedef struct packed {
        logic load;
        logic trivial_res;
        logic pow_init;
        logic mul_acc;
        logic mul_sq;
        logic mul_step;
        logic bound_update;
        logic final_res;
        logic out_load;
    } t_ers_cmd;

    typedef struct packed {
        logic trivial;
        logic lo_lt_hi;
        logic e_bit0;
        logic e_more;
        logic mul_last;
    } t_ers_sts;

endpackage

@@ rtl/ers_datapath.sv @@
// ----------------------------------------------------------------------------
// ers_datapath
// Search bounds, saturating square-and-multiply registers, a shared
// multiplier that forms each product from four half-width partial products,
// and the result and output registers.
// ----------------------------------------------------------------------------
module ers_datapath #(
    parameter int VALUE_BITS = ers_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                          i_clk,
    input  ers_pkg::t_ers_cmd             i_cmd,
    input  logic [VALUE_BITS-1:0]         i_target_value,
    input  logic [ers_pkg::EXP_BITS-1:0]  i_exponent,
    output ers_pkg::t_ers_sts             o_sts,
    output logic                          o_found,
    output logic [VALUE_BITS-1:0]         o_root
);

    localparam int W  = VALUE_BITS + 1;
    localparam int H  = (W + 1) / 2;
    localparam int PW = 2 * H;
    localparam int SW = 4 * H;
    localparam int EB = ers_pkg::EXP_BITS;
    localparam int CB = ers_pkg::MUL_CNT_BITS;

    logic [VALUE_BITS-1:0] r_n;
    logic [EB-1:0]         r_m;
    logic [W-1:0]          r_cap;
    logic [VALUE_BITS-1:0] r_lo;
    logic [VALUE_BITS-1:0] r_hi;
    logic [VALUE_BITS-1:0] r_mid;
    logic [W-1:0]          r_acc;
    logic [W-1:0]          r_sq;
    logic [EB-1:0]         r_e;
    logic                  r_dest_sq;
    logic [CB-1:0]         r_mcnt;
    logic [PW-1:0]         r_pp;
    logic [1:0]            r_ppk;
    logic [SW-1:0]         r_sum;
    logic                  r_res_found;
    logic [VALUE_BITS-1:0] r_res_root;
    logic                  r_out_found;
    logic [VALUE_BITS-1:0] r_out_root;

    logic [VALUE_BITS-1:0] mid_new;
    logic [W-1:0]          op_a;
    logic [PW-1:0]         a_ext;
    logic [PW-1:0]         b_ext;
    logic [H-1:0]          a_part;
    logic [H-1:0]          b_part;
    logic [SW-1:0]         pp_shifted;
    logic [SW-1:0]         sum_next;
    logic [W-1:0]          sat_prod;
    logic                  hit;

    always_comb begin
        mid_new = (r_lo < r_hi) ? (r_lo + ((r_hi - r_lo) >> 1)) : r_lo;
        op_a    = r_dest_sq ? r_sq : r_acc;
        a_ext   = PW'(op_a);
        b_ext   = PW'(r_sq);
        a_part  = r_mcnt[1] ? a_ext[PW-1:H] : a_ext[H-1:0];
        b_part  = r_mcnt[0] ? b_ext[PW-1:H] : b_ext[H-1:0];
        case (r_ppk) inside
            2'd0:       pp_shifted = SW'(r_pp);
            2'd1, 2'd2: pp_shifted = SW'(r_pp) << H;
            default:    pp_shifted = SW'(r_pp) << PW;
        endcase
        sum_next = r_sum + pp_shifted;
        sat_prod = (sum_next > SW'(r_cap)) ? r_cap : sum_next[W-1:0];
        hit      = (r_acc == W'(r_n));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= i_target_value;
            r_m   <= i_exponent;
            r_cap <= W'(i_target_value) + W'(1);
            r_lo  <= '0;
            r_hi  <= i_target_value - VALUE_BITS'(1);
        end
        if (i_cmd.trivial_res) begin
            r_res_found <= (r_m == '0) && (r_n == VALUE_BITS'(1));
            r_res_root  <= '0;
        end
        if (i_cmd.pow_init) begin
            r_mid <= mid_new;
            r_sq  <= W'(mid_new);
            r_acc <= W'(1);
            r_e   <= r_m;
        end
        if (i_cmd.mul_acc || i_cmd.mul_sq) begin
            r_dest_sq <= i_cmd.mul_sq;
            r_mcnt    <= '0;
            r_sum     <= '0;
            if (i_cmd.mul_sq) begin
                r_e <= r_e >> 1;
            end
        end
        if (i_cmd.mul_step) begin
            r_mcnt <= r_mcnt + CB'(1);
            if (r_mcnt != CB'(ers_pkg::MUL_PARTIALS)) begin
                r_pp  <= PW'(a_part) * PW'(b_part);
                r_ppk <= r_mcnt[1:0];
            end
            if (r_mcnt == CB'(ers_pkg::MUL_PARTIALS)) begin
                if (r_dest_sq) begin
                    r_sq <= sat_prod;
                end else begin
                    r_acc <= sat_prod;
                end
            end else if (r_mcnt != '0) begin
                r_sum <= sum_next;
            end
        end
        if (i_cmd.bound_update) begin
            if (r_acc >= W'(r_n)) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid + VALUE_BITS'(1);
            end
        end
        if (i_cmd.final_res) begin
            r_res_found <= hit;
            r_res_root  <= hit ? r_lo : '0;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_res_found;
            r_out_root  <= r_res_root;
        end
    end

    assign o_sts.trivial  = (r_n == '0) || (r_m == '0);
    assign o_sts.lo_lt_hi = (r_lo < r_hi);
    assign o_sts.e_bit0   = r_e[0];
    assign o_sts.e_more   = (r_e[EB-1:1] != '0);
    assign o_sts.mul_last = (r_mcnt == CB'(ers_pkg::MUL_PARTIALS));
    assign o_found        = r_out_found;
    assign o_root         = r_out_root;

endmodule

@@ rtl/ers_controller.sv @@
// ----------------------------------------------------------------------------
// ers_controller
// Sequences one transaction: trivial-case check, bisection over the
// candidates, square-and-multiply for each probe, and result hand-off.
// ----------------------------------------------------------------------------
module ers_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  ers_pkg::t_ers_sts  i_sts,
    output ers_pkg::t_ers_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_BIS,
        S_POW_BIT,
        S_POW_SQ,
        S_MUL,
        S_POW_DONE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_final;
    logic   n_final;
    logic   r_after_sq;
    logic   n_after_sq;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_final     = r_final;
        n_after_sq  = r_after_sq;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.trivial) begin
                    o_cmd.trivial_res = 1'b1;
                    n_state           = S_DONE;
                end else begin
                    n_state = S_BIS;
                end
            end
            S_BIS: begin
                o_cmd.pow_init = 1'b1;
                n_final        = !i_sts.lo_lt_hi;
                n_state        = S_POW_BIT;
            end
            S_POW_BIT: begin
                if (i_sts.e_bit0) begin
                    o_cmd.mul_acc = 1'b1;
                    n_after_sq    = 1'b0;
                    n_state       = S_MUL;
                end else begin
                    n_state = S_POW_SQ;
                end
            end
            S_POW_SQ: begin
                if (i_sts.e_more) begin
                    o_cmd.mul_sq = 1'b1;
                    n_after_sq   = 1'b1;
                    n_state      = S_MUL;
                end else begin
                    n_state = S_POW_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    n_state = r_after_sq ? S_POW_BIT : S_POW_SQ;
                end
            end
            S_POW_DONE: begin
                if (r_final) begin
                    o_cmd.final_res = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.bound_update = 1'b1;
                    n_state            = S_BIS;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_final     <= 1'b0;
            r_after_sq  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_final     <= n_final;
            r_after_sq  <= n_after_sq;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/exact_integer_root_search.sv @@
// ----------------------------------------------------------------------------
// exact_integer_root_search
// Finds the candidate i below n whose m-th power equals n exactly.
//
// The input channel (i_in_valid / o_in_stall) carries a target n and an
// exponent m; the output channel (o_out_valid / i_out_stall) returns one
// transaction per input with a found flag and the root, which is 0 when
// nothing matched. Products are saturated just above n, so overflow never
// produces a false match.
// One transaction is worked on at a time. A zero target or zero exponent
// skips the search. Otherwise the block bisects the candidates, using
// about ceil(log2 n) + 1 probes, and each probe runs square-and-multiply with
// up to 2*bits(m) - 1 products on one shared multiplier that forms each
// product from four half-width partial products plus the saturating add.
// While a finished result is stalled in the output register, the next
// transaction is accepted and computed; it waits for the register to empty.
// Reset clears the controller and the output valid; no transaction survives.
// ----------------------------------------------------------------------------
module exact_integer_root_search #(
    parameter int VALUE_BITS = ers_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [VALUE_BITS-1:0]         i_target_value,
    input  logic [ers_pkg::EXP_BITS-1:0]  i_exponent,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [VALUE_BITS-1:0]         o_root
);

    ers_pkg::t_ers_cmd cmd;
    ers_pkg::t_ers_sts sts;

    ers_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ers_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_target_value (i_target_value),
        .i_exponent     (i_exponent),
        .o_sts          (sts),
        .o_found        (o_found),
        .o_root         (o_root)
    );

endmodule

@@ rtl/ers_checker.sv @@
// ----------------------------------------------------------------------------
// ers_checker
// Port-level checks for the exact integer root search block, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "exact_integer_root_search_macros.svh"

module ers_checker #(
    parameter int VALUE_BITS = ers_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic [VALUE_BITS-1:0]         i_target_value,
    input  logic [ers_pkg::EXP_BITS-1:0]  i_exponent,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic                          o_found,
    input  logic [VALUE_BITS-1:0]         o_root
);

    logic in_xact;
    logic target_zero;

    assign in_xact     = i_in_valid && !o_in_stall;
    assign target_zero = (i_target_value == '0) || (i_exponent == '0);

    `ERS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "output valid dropped while stalled")
    `ERS_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_found) && $stable(o_root), "stalled result changed")
    `ERS_ASSERT_SAME(a_root_zero, o_out_valid && !o_found, o_root == '0, "root not zero without a match")
    `ERS_ASSERT_NEXT(a_one_at_a_time, in_xact && !target_zero, o_in_stall, "second transaction accepted during a search")

endmodule

bind exact_integer_root_search ers_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_ers_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_target_value (i_target_value),
    .i_exponent     (i_exponent),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_found        (o_found),
    .o_root         (o_root)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for exact_integer_root_search
// A table of directed cases covers zero targets, zero and unit exponents and
// the extremes of both fields. It is followed by random perfect powers, their
// near neighbors and plain noise. Each result is compared with the value
// typed in the table, if any, or else with a predictor that bisects the
// candidates and uses saturating square-and-multiply. The sender runs in
// bursts; the receiver stalls on a changing pattern with long hold-offs.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VB = ers_pkg::VALUE_BITS_DEFAULT;
    localparam int EB = ers_pkg::EXP_BITS;
    localparam logic [VB-1:0] TARGET_MAX = '1;
    localparam logic [63:0] TOP_CAP = 64'(TARGET_MAX) + 64'd1;
    localparam int RANDOM_ITEMS = 1150;
    localparam int HOLD_CYCLES = 6000;
    localparam int DRAIN_CYCLES = 3000;
    localparam longint CYCLE_LIMIT = 12_000_000;
    localparam int NUM_DIRECTED = 23;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic          found;
        logic [VB-1:0] root;
    } root_result_t;

    typedef struct packed {
        logic [VB-1:0] target;
        logic [EB-1:0] exponent;
        logic          typed;
        logic          found;
        logic [VB-1:0] root;
    } root_case_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    logic [VB-1:0] i_target_value = '0;
    logic [EB-1:0] i_exponent = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    logic          o_found;
    logic [VB-1:0] o_root;

    root_result_t pending_roots[$];
    int     mismatch_count = 0;
    int     checked_count = 0;
    int     found_count = 0;
    int     zero_exp_count = 0;
    int     burst_left = 0;
    int     holds_done = 0;
    int     hold_requests = 0;
    int     hold_left = 0;
    int     stall_mode = 0;
    int     mode_left = 0;
    longint cycle_count = 0;

    root_case_t directed_cases [NUM_DIRECTED] = '{
        '{31'd0,          6'd0,  1'b1, 1'b0, 31'd0},
        '{31'd0,          6'd63, 1'b1, 1'b0, 31'd0},
        '{TARGET_MAX,     6'd0,  1'b1, 1'b0, 31'd0},
        '{31'd1,          6'd0,  1'b1, 1'b1, 31'd0},
        '{31'd2,          6'd0,  1'b1, 1'b0, 31'd0},
        '{31'd1,          6'd1,  1'b1, 1'b0, 31'd0},
        '{TARGET_MAX,     6'd1,  1'b1, 1'b0, 31'd0},
        '{31'd1,          6'd63, 1'b1, 1'b0, 31'd0},
        '{31'd4,          6'd2,  1'b1, 1'b1, 31'd2},
        '{31'd8,          6'd3,  1'b1, 1'b1, 31'd2},
        '{31'd9,          6'd3,  1'b0, 1'b0, 31'd0},
        '{31'h4000_0000,  6'd2,  1'b0, 1'b0, 31'd0},
        '{31'h4000_0000,  6'd30, 1'b0, 1'b0, 31'd0},
        '{31'h4000_0000,  6'd31, 1'b0, 1'b0, 31'd0},
        '{31'd2147395600, 6'd2,  1'b0, 1'b0, 31'd0},
        '{31'd2147395601, 6'd2,  1'b0, 1'b0, 31'd0},
        '{31'd1162261467, 6'd19, 1'b0, 1'b0, 31'd0},
        '{31'd1162261466, 6'd19, 1'b0, 1'b0, 31'd0},
        '{TARGET_MAX,     6'd2,  1'b0, 1'b0, 31'd0},
        '{TARGET_MAX,     6'd31, 1'b0, 1'b0, 31'd0},
        '{TARGET_MAX,     6'd63, 1'b0, 1'b0, 31'd0},
        '{31'h2AAA_AAAA,  6'd42, 1'b0, 1'b0, 31'd0},
        '{31'h5555_5555,  6'd21, 1'b0, 1'b0, 31'd0}
    };

    exact_integer_root_search #(
        .VALUE_BITS(VB)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_target_value (i_target_value),
        .i_exponent     (i_exponent),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_root         (o_root)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [63:0] clamped_product(input logic [63:0] a, input logic [63:0] b,
                                                     input logic [63:0] cap);
        if (a == 64'd0 || b == 64'd0) begin
            return 64'd0;
        end
        if (b > cap / a) begin
            return cap;
        end
        return (a * b > cap) ? cap : a * b;
    endfunction

    function automatic logic [63:0] clamped_power(input logic [63:0] base,
                                                   input logic [EB-1:0] power_exp,
                                                   input logic [63:0] cap);
        logic [63:0]   acc;
        logic [63:0]   sq;
        logic [EB-1:0] e;
        acc = 64'd1;
        sq = (base > cap) ? cap : base;
        e = power_exp;
        while (e != '0) begin
            if (e[0]) begin
                acc = clamped_product(acc, sq, cap);
            end
            sq = clamped_product(sq, sq, cap);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic root_result_t predict_root_search(input logic [VB-1:0] n,
                                                         input logic [EB-1:0] m);
        root_result_t res;
        logic [63:0]  cap;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        res.found = 1'b0;
        res.root = '0;
        if (n != '0) begin
            if (m == '0) begin
                res.found = (n == VB'(1));
            end else begin
                cap = 64'(n) + 64'd1;
                lo = 64'd0;
                hi = 64'(n) - 64'd1;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 64'd2;
                    if (clamped_power(mid, m, cap) >= 64'(n)) begin
                        hi = mid;
                    end else begin
                        lo = mid + 64'd1;
                    end
                end
                if (clamped_power(lo, m, cap) == 64'(n)) begin
                    res.found = 1'b1;
                    res.root = VB'(lo);
                end
            end
        end
        return res;
    endfunction

    task automatic pick_random_item(output logic [VB-1:0] n, output logic [EB-1:0] m);
        logic [63:0] base;
        logic [63:0] power;
        logic [31:0] mask;
        int          width;
        width = $urandom_range(1, VB);
        mask = 32'((64'd1 << width) - 64'd1);
        if ($urandom_range(99) < 30) begin
            m = EB'($urandom_range(63));
        end else begin
            m = EB'($urandom_range(2, 12));
        end
        if ($urandom_range(99) < 70) begin
            base = 64'($urandom_range(0, mask));
            power = clamped_power(base, m, TOP_CAP);
            while (power > 64'(TARGET_MAX)) begin
                base = base >> 1;
                power = clamped_power(base, m, TOP_CAP);
            end
            case ($urandom_range(3))
                0: begin
                    n = (power != 64'd0) ? VB'(power - 64'd1) : '0;
                end
                1: begin
                    n = (power < 64'(TARGET_MAX)) ? VB'(power + 64'd1) : VB'(power);
                end
                default: begin
                    n = VB'(power);
                end
            endcase
        end else begin
            n = VB'($urandom & mask);
        end
    endtask

    task automatic offer_item(input logic [VB-1:0] n, input logic [EB-1:0] m,
                              input bit has_typed, input root_result_t typed_result);
        int gap;
        i_in_valid <= 1'b1;
        i_target_value <= n;
        i_exponent <= m;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pending_roots.push_back(has_typed ? typed_result : predict_root_search(n, m));
        if (m == '0) begin
            zero_exp_count++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("tb: mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_result();
        root_result_t want;
        if (pending_roots.size() == 0) begin
            report_mismatch("unexpected transaction, found", 64'(o_found), 64'd0);
        end else begin
            want = pending_roots.pop_front();
            checked_count++;
            if (want.found) begin
                found_count++;
            end
            if (o_found !== want.found) begin
                report_mismatch("found", 64'(o_found), 64'(want.found));
            end
            if (o_root !== want.root) begin
                report_mismatch("root", 64'(o_root), 64'(want.root));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_result();
        end
        if (holds_done < hold_requests && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(3);
            mode_left = $urandom_range(64, 512);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(3) == 0);
                2: i_out_stall <= ($urandom_range(3) != 0);
                default: i_out_stall <= (cycle_count % 8 < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout with %0d transactions outstanding", pending_roots.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [VB-1:0] n;
        logic [EB-1:0] m;
        root_result_t  typed_result;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < NUM_DIRECTED; k++) begin
            typed_result.found = directed_cases[k].found;
            typed_result.root = directed_cases[k].root;
            offer_item(directed_cases[k].target, directed_cases[k].exponent,
                       directed_cases[k].typed, typed_result);
        end
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 100 || k == 700) begin
                hold_requests++;
            end
            pick_random_item(n, m);
            offer_item(n, m, 1'b0, typed_result);
        end
        i_in_valid <= 1'b0;
        while (pending_roots.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d transactions checked, %0d with an exact root, %0d zero exponents",
                 checked_count, found_count, zero_exp_count);
        $display("summary: %0d long output hold-offs, %0d cycles, %0d mismatches",
                 holds_done, cycle_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
